// ----- rtl/serial_command_line_parser_assert.svh -----
// Assertion macros for the serial command line parser.
`ifndef SERIAL_COMMAND_LINE_PARSER_ASSERT_SVH
`define SERIAL_COMMAND_LINE_PARSER_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define SCLP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sclp check failed: same-cycle implication");

// Check that cons holds in the cycle after ante.
`define SCLP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sclp check failed: next-cycle implication");

`endif

// ----- rtl/sclp_pkg.sv -----
// Package with character codes, parse phases and kind codes of the command line parser.
package sclp_pkg;

    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam logic [7:0] CHAR_C_UP = 8'h43;
    localparam logic [7:0] CHAR_C_LO = 8'h63;
    localparam logic [7:0] CHAR_W_UP = 8'h57;
    localparam logic [7:0] CHAR_W_LO = 8'h77;
    localparam logic [7:0] CHAR_R_UP = 8'h52;
    localparam logic [7:0] CHAR_R_LO = 8'h72;
    localparam logic [7:0] CHAR_N_UP = 8'h4E;
    localparam logic [7:0] CHAR_N_LO = 8'h6E;

    localparam int ARG_W = 32;
    localparam int NUM_W = 7;
    localparam int KIND_W = 2;
    localparam int PHASE_W = 3;

    localparam logic [NUM_W-1:0] NUM_LIMIT = 7'd10;
    localparam logic [NUM_W-1:0] NUM_MAX   = 7'd99;

    localparam logic [PHASE_W-1:0] PH_TYPE = 3'd0;
    localparam logic [PHASE_W-1:0] PH_ID   = 3'd1;
    localparam logic [PHASE_W-1:0] PH_ARG1 = 3'd2;
    localparam logic [PHASE_W-1:0] PH_ARG2 = 3'd3;
    localparam logic [PHASE_W-1:0] PH_DONE = 3'd4;

    localparam logic [KIND_W-1:0] KIND_COMMON   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WATCHDOG = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RANDOM   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_RADIO    = 2'd3;

endpackage

// ----- rtl/serial_command_line_parser.sv -----
// Serial command line parser: byte register, parse state update and result register.
// Accepts one ASCII byte per cycle while no held result stalls it, and parses lines of the form T<id>:<a1>:<a2>
// closed by a newline (T is C, W, R or N in either case; carriage returns are ignored).
// A newline byte waits in the byte register, and its result is then registered in the output register,
// which waits while an earlier result is still held there.
// The rate is one item per cycle, set by the combinational parse step: one 32-bit
// multiply-by-ten-and-add on the argument being built. Both sides are decoupled by
// registers; the input stalls only while a held result is not taken.
`include "serial_command_line_parser_assert.svh"

module serial_command_line_parser (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [7:0]                           i_rx_byte,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [sclp_pkg::KIND_W-1:0]          o_command_kind,
    output logic [sclp_pkg::NUM_W-1:0]           o_command_number,
    output logic signed [sclp_pkg::ARG_W-1:0]    o_first_argument,
    output logic signed [sclp_pkg::ARG_W-1:0]    o_second_argument
);

    // Input byte register
    logic                              r_in_valid;
    logic [7:0]                        r_in_byte;

    // Parse state
    logic [sclp_pkg::PHASE_W-1:0]      r_phase,  n_phase;
    logic [sclp_pkg::KIND_W-1:0]       r_kind,   n_kind;
    logic [sclp_pkg::NUM_W-1:0]        r_number, n_number;
    logic [sclp_pkg::ARG_W-1:0]        r_arg1,   n_arg1;
    logic [sclp_pkg::ARG_W-1:0]        r_arg2,   n_arg2;

    // Result register
    logic                              r_out_valid;
    logic [sclp_pkg::KIND_W-1:0]       r_out_kind;
    logic [sclp_pkg::NUM_W-1:0]        r_out_number;
    logic [sclp_pkg::ARG_W-1:0]        r_out_arg1;
    logic [sclp_pkg::ARG_W-1:0]        r_out_arg2;

    logic                              w_advance;
    logic                              w_emit;
    logic [sclp_pkg::PHASE_W-1:0]      w_base_phase;
    logic [sclp_pkg::NUM_W-1:0]        w_base_number;
    logic [sclp_pkg::ARG_W-1:0]        w_base_arg1;
    logic [sclp_pkg::ARG_W-1:0]        w_base_arg2;
    logic                              w_is_digit;
    logic [3:0]                        w_digit;
    logic [sclp_pkg::NUM_W-1:0]        w_num_next;
    logic [sclp_pkg::ARG_W-1:0]        w_arg1_next;
    logic [sclp_pkg::ARG_W-1:0]        w_arg2_next;

    assign w_advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready   = !r_in_valid || w_advance;

    // A finished command clears the phase, number and arguments before the next byte is handled.
    assign w_base_phase  = (r_phase == sclp_pkg::PH_DONE) ? sclp_pkg::PH_TYPE : r_phase;
    assign w_base_number = (r_phase == sclp_pkg::PH_DONE) ? '0 : r_number;
    assign w_base_arg1   = (r_phase == sclp_pkg::PH_DONE) ? '0 : r_arg1;
    assign w_base_arg2   = (r_phase == sclp_pkg::PH_DONE) ? '0 : r_arg2;

    assign w_is_digit = r_in_byte inside {[sclp_pkg::CHAR_ZERO:sclp_pkg::CHAR_NINE]};
    assign w_digit    = r_in_byte[3:0];

    // x*10 + d as (x<<3) + (x<<1) + d
    assign w_num_next  = {w_base_number[3:0], 3'b000} + {w_base_number[5:0], 1'b0}
                       + {3'b000, w_digit};
    assign w_arg1_next = {w_base_arg1[28:0], 3'b000} + {w_base_arg1[30:0], 1'b0}
                       + {28'd0, w_digit};
    assign w_arg2_next = {w_base_arg2[28:0], 3'b000} + {w_base_arg2[30:0], 1'b0}
                       + {28'd0, w_digit};

    always_comb begin
        n_phase  = w_base_phase;
        n_kind   = r_kind;
        n_number = w_base_number;
        n_arg1   = w_base_arg1;
        n_arg2   = w_base_arg2;
        w_emit   = 1'b0;
        if (r_in_byte == sclp_pkg::CHAR_CR) begin
            // ignore carriage return, keep the cleared state after a command
        end else if (r_in_byte == sclp_pkg::CHAR_COLON) begin
            if (w_base_phase == sclp_pkg::PH_ID) begin
                n_phase = sclp_pkg::PH_ARG1;
            end else if (w_base_phase == sclp_pkg::PH_ARG1) begin
                n_phase = sclp_pkg::PH_ARG2;
            end else begin
                n_phase  = sclp_pkg::PH_TYPE;
                n_number = '0;
                n_arg1   = '0;
                n_arg2   = '0;
            end
        end else if (r_in_byte == sclp_pkg::CHAR_LF) begin
            // the type is known exactly in the id and argument phases
            if (w_base_phase inside {sclp_pkg::PH_ID, sclp_pkg::PH_ARG1, sclp_pkg::PH_ARG2}) begin
                n_phase = sclp_pkg::PH_DONE;
                w_emit  = 1'b1;
            end else begin
                n_phase  = sclp_pkg::PH_TYPE;
                n_number = '0;
                n_arg1   = '0;
                n_arg2   = '0;
            end
        end else begin
            case (w_base_phase)
                sclp_pkg::PH_TYPE: begin
                    case (r_in_byte)
                        sclp_pkg::CHAR_C_UP, sclp_pkg::CHAR_C_LO: begin
                            n_kind  = sclp_pkg::KIND_COMMON;
                            n_phase = sclp_pkg::PH_ID;
                        end
                        sclp_pkg::CHAR_W_UP, sclp_pkg::CHAR_W_LO: begin
                            n_kind  = sclp_pkg::KIND_WATCHDOG;
                            n_phase = sclp_pkg::PH_ID;
                        end
                        sclp_pkg::CHAR_R_UP, sclp_pkg::CHAR_R_LO: begin
                            n_kind  = sclp_pkg::KIND_RANDOM;
                            n_phase = sclp_pkg::PH_ID;
                        end
                        sclp_pkg::CHAR_N_UP, sclp_pkg::CHAR_N_LO: begin
                            n_kind  = sclp_pkg::KIND_RADIO;
                            n_phase = sclp_pkg::PH_ID;
                        end
                        default: begin
                            n_phase = sclp_pkg::PH_TYPE;
                        end
                    endcase
                end
                sclp_pkg::PH_ID: begin
                    if (w_is_digit && (w_base_number < sclp_pkg::NUM_LIMIT)) begin
                        n_number = w_num_next;
                    end else begin
                        n_phase  = sclp_pkg::PH_TYPE;
                        n_number = '0;
                        n_arg1   = '0;
                        n_arg2   = '0;
                    end
                end
                sclp_pkg::PH_ARG1: begin
                    if (w_is_digit) begin
                        n_arg1 = w_arg1_next;
                    end else begin
                        n_phase  = sclp_pkg::PH_TYPE;
                        n_number = '0;
                        n_arg1   = '0;
                        n_arg2   = '0;
                    end
                end
                sclp_pkg::PH_ARG2: begin
                    if (w_is_digit) begin
                        n_arg2 = w_arg2_next;
                    end else begin
                        n_phase  = sclp_pkg::PH_TYPE;
                        n_number = '0;
                        n_arg1   = '0;
                        n_arg2   = '0;
                    end
                end
                default: begin
                    n_phase  = sclp_pkg::PH_TYPE;
                    n_number = '0;
                    n_arg1   = '0;
                    n_arg2   = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= sclp_pkg::PH_TYPE;
            r_kind      <= sclp_pkg::KIND_COMMON;
            r_number    <= '0;
            r_arg1      <= '0;
            r_arg2      <= '0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (w_advance) begin
                r_phase     <= n_phase;
                r_kind      <= n_kind;
                r_number    <= n_number;
                r_arg1      <= n_arg1;
                r_arg2      <= n_arg2;
                r_out_valid <= w_emit;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: load on accept / emit, no reset needed.
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_rx_byte;
        end
        if (w_advance && w_emit) begin
            r_out_kind   <= r_kind;
            r_out_number <= w_base_number;
            r_out_arg1   <= w_base_arg1;
            r_out_arg2   <= w_base_arg2;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_command_kind    = r_out_kind;
    assign o_command_number  = r_out_number;
    assign o_first_argument  = signed'(r_out_arg1);
    assign o_second_argument = signed'(r_out_arg2);

    `SCLP_ASSERT_NEXT(a_emit_shows, i_clk, i_rst_n, w_advance && w_emit, o_valid)
    `SCLP_ASSERT_NOW(a_phase_range, i_clk, i_rst_n, 1'b1, r_phase <= sclp_pkg::PH_DONE)
    `SCLP_ASSERT_NOW(a_type_clear, i_clk, i_rst_n, r_phase == sclp_pkg::PH_TYPE,
        (r_number == '0) && (r_arg1 == '0) && (r_arg2 == '0))
    `SCLP_ASSERT_NOW(a_arg2_idle, i_clk, i_rst_n,
        (r_phase == sclp_pkg::PH_ID) || (r_phase == sclp_pkg::PH_ARG1), r_arg2 == '0)
    `SCLP_ASSERT_NOW(a_number_range, i_clk, i_rst_n, 1'b1, r_number <= sclp_pkg::NUM_MAX)

endmodule

// ----- test/serial_command_line_parser_tb.sv -----
// Self-checking testbench for the serial command line parser: random byte streams, scoreboard.
`timescale 1ns / 100ps

module serial_command_line_parser_tb;

    localparam logic [2:0] KIND_NONE = 3'd4;
    localparam int SETTLE_CYCLES = 10;
    localparam int HOLD_CYCLES = 80;

    typedef struct {
        logic [7:0] value;
        bit         wait_drain;
    } t_tx_item;

    typedef struct {
        logic [sclp_pkg::KIND_W-1:0]       kind;
        logic [sclp_pkg::NUM_W-1:0]        number;
        logic signed [sclp_pkg::ARG_W-1:0] first;
        logic signed [sclp_pkg::ARG_W-1:0] second;
    } t_command;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                i_valid = 1'b0;
    logic                                o_ready;
    logic [7:0]                          i_rx_byte = 8'h00;
    logic                                o_valid;
    logic                                i_ready = 1'b0;
    logic [sclp_pkg::KIND_W-1:0]         o_command_kind;
    logic [sclp_pkg::NUM_W-1:0]          o_command_number;
    logic signed [sclp_pkg::ARG_W-1:0]   o_first_argument;
    logic signed [sclp_pkg::ARG_W-1:0]   o_second_argument;

    t_tx_item tx_bytes[$];
    t_command expected_cmds[$];
    int       outstanding = 0;
    int       errors = 0;
    int       results_seen = 0;
    int       holds_done = 0;
    int       hold_left = 0;
    int       cycle_count = 0;
    logic     quiet;

    // line parser shadow state
    logic [sclp_pkg::PHASE_W-1:0] line_phase;
    logic [2:0]                   line_kind;
    logic [sclp_pkg::NUM_W-1:0]   line_number;
    logic [sclp_pkg::ARG_W-1:0]   line_arg1;
    logic [sclp_pkg::ARG_W-1:0]   line_arg2;

    logic [7:0] type_letters [8] = '{sclp_pkg::CHAR_C_UP, sclp_pkg::CHAR_C_LO,
                                     sclp_pkg::CHAR_W_UP, sclp_pkg::CHAR_W_LO,
                                     sclp_pkg::CHAR_R_UP, sclp_pkg::CHAR_R_LO,
                                     sclp_pkg::CHAR_N_UP, sclp_pkg::CHAR_N_LO};

    serial_command_line_parser i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_rx_byte         (i_rx_byte),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_command_kind    (o_command_kind),
        .o_command_number  (o_command_number),
        .o_first_argument  (o_first_argument),
        .o_second_argument (o_second_argument)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    assign quiet = (cycle_count >= 200) && (cycle_count < 420);

    function automatic void clear_line();
        line_phase  = sclp_pkg::PH_TYPE;
        line_kind   = KIND_NONE;
        line_number = '0;
        line_arg1   = '0;
        line_arg2   = '0;
    endfunction

    // Advance the shadow parser by one byte; queue a command on a closing newline.
    function automatic void parse_byte(input logic [7:0] b);
        t_command cmd;
        logic     is_digit;
        is_digit = (b >= sclp_pkg::CHAR_ZERO) && (b <= sclp_pkg::CHAR_NINE);
        if (line_phase == sclp_pkg::PH_DONE) clear_line();
        if (b == sclp_pkg::CHAR_CR) return;
        if (b == sclp_pkg::CHAR_COLON) begin
            if (line_phase == sclp_pkg::PH_ID) line_phase = sclp_pkg::PH_ARG1;
            else if (line_phase == sclp_pkg::PH_ARG1) line_phase = sclp_pkg::PH_ARG2;
            else clear_line();
        end else if (b == sclp_pkg::CHAR_LF) begin
            if (line_kind != KIND_NONE) begin
                cmd.kind   = line_kind[sclp_pkg::KIND_W-1:0];
                cmd.number = line_number;
                cmd.first  = line_arg1;
                cmd.second = line_arg2;
                expected_cmds.push_back(cmd);
                line_phase = sclp_pkg::PH_DONE;
            end else begin
                clear_line();
            end
        end else begin
            case (line_phase)
                sclp_pkg::PH_TYPE: begin
                    line_phase = sclp_pkg::PH_ID;
                    case (b)
                        sclp_pkg::CHAR_C_UP, sclp_pkg::CHAR_C_LO:
                            line_kind = {1'b0, sclp_pkg::KIND_COMMON};
                        sclp_pkg::CHAR_W_UP, sclp_pkg::CHAR_W_LO:
                            line_kind = {1'b0, sclp_pkg::KIND_WATCHDOG};
                        sclp_pkg::CHAR_R_UP, sclp_pkg::CHAR_R_LO:
                            line_kind = {1'b0, sclp_pkg::KIND_RANDOM};
                        sclp_pkg::CHAR_N_UP, sclp_pkg::CHAR_N_LO:
                            line_kind = {1'b0, sclp_pkg::KIND_RADIO};
                        default: begin
                            line_kind  = KIND_NONE;
                            line_phase = sclp_pkg::PH_TYPE;
                        end
                    endcase
                end
                sclp_pkg::PH_ID: begin
                    if (is_digit && line_number < sclp_pkg::NUM_LIMIT)
                        line_number = line_number * 7'd10 + 7'(b - sclp_pkg::CHAR_ZERO);
                    else
                        clear_line();
                end
                sclp_pkg::PH_ARG1: begin
                    if (is_digit)
                        line_arg1 = line_arg1 * 32'd10 + 32'(b - sclp_pkg::CHAR_ZERO);
                    else clear_line();
                end
                sclp_pkg::PH_ARG2: begin
                    if (is_digit)
                        line_arg2 = line_arg2 * 32'd10 + 32'(b - sclp_pkg::CHAR_ZERO);
                    else clear_line();
                end
                default: clear_line();
            endcase
        end
    endfunction

    // Driver: present the next queued byte, idling at random.
    always @(posedge i_clk) begin
        logic accepting;
        logic idle_now;
        accepting = i_valid && o_ready;
        idle_now  = !quiet && ($urandom_range(99) < 34);
        if (!i_rst_n) begin
            i_valid   <= 1'b0;
            i_rx_byte <= 8'h00;
        end else if (!i_valid || accepting) begin
            if (tx_bytes.size() != 0 && !idle_now &&
                !(tx_bytes[0].wait_drain && (accepting || outstanding != 0))) begin
                i_valid   <= 1'b1;
                i_rx_byte <= tx_bytes.pop_front().value;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Monitor: predict on accepted bytes, check accepted commands, drive ready.
    always @(posedge i_clk) begin
        t_command want;
        if (!i_rst_n) begin
            clear_line();
            i_ready <= 1'b0;
        end else begin
            if (i_valid && o_ready) parse_byte(i_rx_byte);
            if (o_valid && i_ready) begin
                results_seen++;
                if (expected_cmds.size() == 0) begin
                    $display("%0t: unexpected command kind=%0d number=%0d args=%0d,%0d",
                             $time, o_command_kind, o_command_number,
                             o_first_argument, o_second_argument);
                    errors++;
                end else begin
                    want = expected_cmds.pop_front();
                    if (o_command_kind !== want.kind) begin
                        $display("%0t: command_kind expected %0d actual %0d",
                                 $time, want.kind, o_command_kind);
                        errors++;
                    end
                    if (o_command_number !== want.number) begin
                        $display("%0t: command_number expected %0d actual %0d",
                                 $time, want.number, o_command_number);
                        errors++;
                    end
                    if (o_first_argument !== want.first) begin
                        $display("%0t: first_argument expected %0d actual %0d",
                                 $time, want.first, o_first_argument);
                        errors++;
                    end
                    if (o_second_argument !== want.second) begin
                        $display("%0t: second_argument expected %0d actual %0d",
                                 $time, want.second, o_second_argument);
                        errors++;
                    end
                end
            end
            outstanding <= expected_cmds.size();
            // long hold-offs after the fourth and the twentieth command so the input backs up
            if (hold_left != 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (holds_done < 2 && results_seen >= (holds_done == 0 ? 4 : 20)) begin
                holds_done++;
                hold_left = HOLD_CYCLES;
                i_ready <= 1'b0;
            end else begin
                i_ready <= quiet || ($urandom_range(99) >= 34);
            end
        end
    end

    task automatic push_byte(input logic [7:0] b, input bit drain);
        t_tx_item it;
        it.value      = b;
        it.wait_drain = drain;
        tx_bytes.push_back(it);
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) push_byte(s[i], 1'b0);
    endtask

    // Push a byte of a line, now and then followed by a carriage return.
    task automatic line_byte(input logic [7:0] b);
        push_byte(b, 1'b0);
        if ($urandom_range(99) < 8) push_byte(sclp_pkg::CHAR_CR, 1'b0);
    endtask

    task automatic push_digits(input int count);
        for (int i = 0; i < count; i++)
            line_byte(sclp_pkg::CHAR_ZERO + 8'($urandom_range(9)));
    endtask

    function automatic int arg_length();
        return ($urandom_range(9) == 0) ? $urandom_range(12, 10) : $urandom_range(4);
    endfunction

    // Send up to two junk bytes, then a full command; the first byte may wait for a drain.
    task automatic gen_command(input bit drain);
        int junk;
        junk = ($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0;
        for (int i = 0; i < junk; i++) push_byte(8'($urandom_range(255)), drain && i == 0);
        push_byte(type_letters[$urandom_range(7)], drain && junk == 0);
        push_digits($urandom_range(2));
        if ($urandom_range(9) != 0) begin
            line_byte(sclp_pkg::CHAR_COLON);
            push_digits(arg_length());
            if ($urandom_range(9) != 0) begin
                line_byte(sclp_pkg::CHAR_COLON);
                push_digits(arg_length());
            end
        end
        push_byte(sclp_pkg::CHAR_LF, 1'b0);
    endtask

    task automatic gen_broken();
        case ($urandom_range(3))
            0: begin
                repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(255)), 1'b0);
            end
            1: begin
                line_byte(type_letters[$urandom_range(7)]);
                push_digits($urandom_range(2));
                if ($urandom_range(1)) begin
                    line_byte(sclp_pkg::CHAR_COLON);
                    push_digits($urandom_range(3));
                end
                push_byte(8'($urandom_range(255)), 1'b0);
                push_byte(sclp_pkg::CHAR_LF, 1'b0);
            end
            2: begin
                line_byte(type_letters[$urandom_range(7)]);
                push_digits(3);
                push_byte(sclp_pkg::CHAR_LF, 1'b0);
            end
            default: begin
                line_byte(type_letters[$urandom_range(7)]);
                push_digits($urandom_range(2));
                repeat (3) begin
                    line_byte(sclp_pkg::CHAR_COLON);
                    push_digits($urandom_range(2));
                end
                push_byte(sclp_pkg::CHAR_LF, 1'b0);
            end
        endcase
    endtask

    initial begin
        int lines;
        // extremes of the byte, skipped before a type letter
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        // bare command: all fields zero, then the next line starts clean
        push_text("W\n");
        // misplaced colon and a newline without a type letter
        push_text(":\n");
        // third id digit drops the line
        push_text("c123\n");
        // non-digit in an argument drops the line
        push_text("R9:/\n");
        // argument wraps past 32 bits
        push_text("n:5000000000:7\r\n");

        lines = 0;
        while (tx_bytes.size() < 430) begin
            if ($urandom_range(99) < 80) gen_command(lines == 10 || $urandom_range(99) < 6);
            else gen_broken();
            lines++;
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(negedge i_clk);
        while (tx_bytes.size() != 0 || i_valid || outstanding != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        while (expected_cmds.size() != 0) begin
            $display("%0t: missing command expected kind=%0d number=%0d args=%0d,%0d actual none",
                     $time, expected_cmds[0].kind, expected_cmds[0].number,
                     expected_cmds[0].first, expected_cmds[0].second);
            void'(expected_cmds.pop_front());
            errors++;
        end

        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
